// ===== rtl/msk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_pkg - mail address skinner shared definitions
// Payload structs, scan modes, character codes and the step helpers.
// ----------------------------------------------------------------------------
package msk_pkg;

	localparam int MAX_RES              = 4;
	localparam int DEF_MAX_PAREN_DEPTH  = 255;
	localparam int DEF_QUEUE_DEPTH      = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_T      = 8'h74;

	typedef enum logic [2:0] {
		M_NORMAL,
		M_SPACE,
		M_SP_A,
		M_SP_AT,
		M_SP_ATSIGN,
		M_COMMENT,
		M_SKIP,
		M_DONE
	} msk_mode_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} msk_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       restart;
		logic       out_end;
	} msk_out_t;

	// results raised by one input item
	typedef struct packed {
		logic [2:0]           count;
		msk_out_t [MAX_RES-1:0] res;
	} msk_bundle_t;

	typedef struct packed {
		msk_mode_t   mode;
		logic        space_pending;
		logic        angle_seen;
		logic        open_comment;
		logic        ended;
		msk_bundle_t bundle;
	} msk_work_t;

	function automatic msk_work_t msk_put(msk_work_t w, logic [7:0] ch, logic has,
			logic rst);
		msk_work_t r;
		r = w;
		if (r.bundle.count < 3'(MAX_RES)) begin
			r.bundle.res[r.bundle.count[1:0]] = '{out_char: ch, has_char: has,
				restart: rst, out_end: 1'b0};
			r.bundle.count = r.bundle.count + 3'd1;
		end
		return r;
	endfunction

	function automatic msk_work_t msk_keep(msk_work_t w, logic [7:0] ch);
		msk_work_t r;
		r = w;
		if (r.space_pending) begin
			r.space_pending = 1'b0;
			r = msk_put(r, CH_SPACE, 1'b1, 1'b0);
		end
		r = msk_put(r, ch, 1'b1, 1'b0);
		return r;
	endfunction

	function automatic msk_work_t msk_normal(msk_work_t w, logic [7:0] ch);
		msk_work_t r;
		r = w;
		r.mode = M_NORMAL;
		if (ch == CH_LPAREN) begin
			r.open_comment  = 1'b1;
			r.mode          = M_COMMENT;
			r.space_pending = 1'b0;
		end else if (ch == CH_SPACE) begin
			r.mode = M_SPACE;
		end else if (ch == CH_LT) begin
			r = msk_put(r, CH_NUL, 1'b0, 1'b1);
			r.angle_seen    = 1'b1;
			r.space_pending = 1'b0;
		end else if (ch == CH_GT && r.angle_seen) begin
			r.mode  = M_DONE;
			r.ended = 1'b1;
		end else begin
			r = msk_keep(r, ch);
		end
		return r;
	endfunction

endpackage

// ===== rtl/msk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_front - character scanner
// Takes one character a cycle while the queue is not full, tracks comments
// and lookahead, and builds the bundle of results that the character raises.
// ----------------------------------------------------------------------------
module msk_front
	import msk_pkg::*;
#(
	parameter int MAX_PAREN_DEPTH = DEF_MAX_PAREN_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  msk_in_t     char_data,
	input  logic        q_full,
	output logic        push,
	output msk_bundle_t bundle
);

	localparam int PW = $clog2(MAX_PAREN_DEPTH + 1);

	msk_mode_t  mode_q, mode_d;
	logic [PW-1:0] depth_q, depth_d, depth_step;
	logic       sp_q, sp_d;
	logic       angle_q, angle_d;
	msk_work_t  w;
	logic       accept;
	logic [7:0] c;
	logic       last;

	assign c          = char_data.in_char;
	assign last       = char_data.in_last;
	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;

	always_comb begin
		w            = '0;
		w.mode       = mode_q;
		w.space_pending = sp_q;
		w.angle_seen = angle_q;
		depth_step   = depth_q;
		case (mode_q)
			M_DONE: begin
			end
			M_COMMENT: begin
				if (c == CH_LPAREN) begin
					if (depth_q < PW'(MAX_PAREN_DEPTH))
						depth_step = depth_q + PW'(1);
				end else if (c == CH_RPAREN) begin
					if (depth_q != '0)
						depth_step = depth_q - PW'(1);
					if (depth_q <= PW'(1))
						w.mode = M_SKIP;
				end
			end
			M_SKIP: begin
				w.mode = M_NORMAL;
			end
			M_SPACE: begin
				if (c == CH_A) begin
					w.mode = M_SP_A;
				end else if (c == CH_AT) begin
					w.mode = M_SP_ATSIGN;
				end else begin
					w.space_pending = 1'b1;
					w = msk_normal(w, c);
				end
			end
			M_SP_A: begin
				if (c == CH_T) begin
					w.mode = M_SP_AT;
				end else begin
					w.space_pending = 1'b1;
					w = msk_keep(w, CH_A);
					w = msk_normal(w, c);
				end
			end
			M_SP_AT: begin
				if (c == CH_SPACE) begin
					w = msk_put(w, CH_AT, 1'b1, 1'b0);
					w.mode = M_NORMAL;
				end else begin
					w.space_pending = 1'b1;
					w = msk_keep(w, CH_A);
					w = msk_keep(w, CH_T);
					w = msk_normal(w, c);
				end
			end
			M_SP_ATSIGN: begin
				if (c == CH_SPACE) begin
					w = msk_put(w, CH_AT, 1'b1, 1'b0);
					w.mode = M_NORMAL;
				end else begin
					w.space_pending = 1'b1;
					w = msk_keep(w, CH_AT);
					w = msk_normal(w, c);
				end
			end
			default: begin
				w = msk_normal(w, c);
			end
		endcase

		// flush held lookahead on the final character
		if (last && mode_q != M_DONE && !w.ended) begin
			case (w.mode)
				M_SP_A: begin
					w.space_pending = 1'b1;
					w = msk_keep(w, CH_A);
				end
				M_SP_AT: begin
					w.space_pending = 1'b1;
					w = msk_keep(w, CH_A);
					w = msk_keep(w, CH_T);
				end
				M_SP_ATSIGN: begin
					w.space_pending = 1'b1;
					w = msk_keep(w, CH_AT);
				end
				default: begin
				end
			endcase
			w.ended = 1'b1;
		end

		if (w.ended) begin
			if (w.bundle.count == 3'd0)
				w = msk_put(w, CH_NUL, 1'b0, 1'b0);
			w.bundle.res[2'(w.bundle.count - 3'd1)].out_end = 1'b1;
		end
	end

	// next state
	always_comb begin
		if (last) begin
			mode_d  = M_NORMAL;
			depth_d = '0;
			sp_d    = 1'b0;
			angle_d = 1'b0;
		end else begin
			mode_d  = w.mode;
			depth_d = w.open_comment ? PW'(1) : depth_step;
			sp_d    = w.space_pending;
			angle_d = w.angle_seen;
		end
	end

	// outputs
	always_comb begin
		bundle = w.bundle;
		push   = accept && (w.bundle.count != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			depth_q <= '0;
			sp_q    <= 1'b0;
			angle_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			depth_q <= depth_d;
			sp_q    <= sp_d;
			angle_q <= angle_d;
		end
	end

endmodule

// ===== rtl/msk_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_queue - result bundle queue
// Short first-in first-out store of result bundles between scanner and
// output serialiser.
// ----------------------------------------------------------------------------
module msk_queue
	import msk_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  msk_bundle_t wr_data,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output msk_bundle_t head
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	msk_bundle_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== rtl/msk_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_back - output serialiser
// Walks the head bundle one result a cycle, if not stalled, into out_q.
// ----------------------------------------------------------------------------
module msk_back
	import msk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  msk_bundle_t head,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_stall,
	output msk_out_t    res_data
);

	logic       out_valid_q;
	msk_out_t   out_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load     = head_valid && (!out_valid_q || !res_stall);
	assign at_last  = ({1'b0, idx_q} == (head.count - 3'd1));
	assign pop      = load && at_last;
	assign res_valid = out_valid_q;
	assign res_data = out_q;

	always_ff @(posedge clk) begin
		if (load)
			out_q <= head.res[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (!out_valid_q || !res_stall)
				out_valid_q <= head_valid;
			if (load)
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/mail_address_skinner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mail_address_skinner - address skinner top level
// Strips comments and folds spacing of an address, one character at a time.
//
//   channel  direction  payload    transfer when
//   char     in         msk_in_t   char_valid && !char_stall
//   res      out        msk_out_t  res_valid && !res_stall
//
// One character is taken each cycle while the bundle queue has room; the
// output register gives one result per cycle when res_stall is low, so
// characters raising more than one result (up to four) fill the queue.
// A character's results pass through the queue and the output register.
// Reset clears scan state, queue pointers and the output valid.
// char_stall follows only the queue-full flag.
// ----------------------------------------------------------------------------
module mail_address_skinner
	import msk_pkg::*;
#(
	parameter int MAX_PAREN_DEPTH = DEF_MAX_PAREN_DEPTH,
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	output logic     char_stall,
	input  msk_in_t  char_data,
	output logic     res_valid,
	input  logic     res_stall,
	output msk_out_t res_data
);

	logic        push, full, pop, head_valid;
	msk_bundle_t wr_bundle, head;

	msk_front #(
		.MAX_PAREN_DEPTH(MAX_PAREN_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data (char_data),
		.q_full    (full),
		.push      (push),
		.bundle    (wr_bundle)
	);

	msk_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (wr_bundle),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	msk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - mail address skinner testbench
// Streams addresses through the DUT and checks every result transfer against
// a directed row's result, else an in-bench model of comment stripping,
// " at " / " @ " folding, space folding and angle-bracket restart. Directed
// rows lead, then random addresses in phases of send gaps and result stall.
// ----------------------------------------------------------------------------
module tb;
	import msk_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       known;
		msk_out_t   want;
	} char_row_t;

	localparam msk_out_t UNTYPED = '0;
	localparam int MAX_DEPTH = DEF_MAX_PAREN_DEPTH;
	localparam logic [7:0] AT_WORD [4] = '{CH_SPACE, CH_A, CH_T, CH_SPACE};
	localparam logic [7:0] ATSIGN_WORD [3] = '{CH_SPACE, CH_AT, CH_SPACE};
	localparam int SEND_PCT [4] = '{0, 72, 0, 33};
	localparam int STALL_PCT [4] = '{0, 0, 72, 33};

	localparam char_row_t DIRECTED [25] = '{
		'{"x",       1'b0, 1'b1, '{"x",     1'b1, 1'b0, 1'b0}},
		'{8'hff,     1'b0, 1'b1, '{8'hff,   1'b1, 1'b0, 1'b0}},
		'{8'h01,     1'b1, 1'b1, '{8'h01,   1'b1, 1'b0, 1'b1}},
		'{CH_SPACE,  1'b0, 1'b0, UNTYPED},
		'{CH_A,      1'b0, 1'b0, UNTYPED},
		'{CH_T,      1'b0, 1'b0, UNTYPED},
		'{CH_SPACE,  1'b0, 1'b1, '{CH_AT,   1'b1, 1'b0, 1'b0}},
		'{"b",       1'b1, 1'b1, '{"b",     1'b1, 1'b0, 1'b1}},
		'{CH_LPAREN, 1'b0, 1'b0, UNTYPED},
		'{CH_RPAREN, 1'b0, 1'b0, UNTYPED},
		'{"z",       1'b0, 1'b0, UNTYPED},
		'{"q",       1'b1, 1'b1, '{"q",     1'b1, 1'b0, 1'b1}},
		'{"y",       1'b0, 1'b1, '{"y",     1'b1, 1'b0, 1'b0}},
		'{CH_SPACE,  1'b0, 1'b0, UNTYPED},
		'{CH_AT,     1'b0, 1'b0, UNTYPED},
		'{"k",       1'b1, 1'b0, UNTYPED},
		'{CH_LT,     1'b0, 1'b1, '{CH_NUL,  1'b0, 1'b1, 1'b0}},
		'{"m",       1'b0, 1'b0, UNTYPED},
		'{CH_GT,     1'b0, 1'b1, '{CH_NUL,  1'b0, 1'b0, 1'b1}},
		'{"w",       1'b0, 1'b0, UNTYPED},
		'{"v",       1'b1, 1'b0, UNTYPED},
		'{CH_SPACE,  1'b0, 1'b0, UNTYPED},
		'{CH_A,      1'b1, 1'b0, UNTYPED},
		'{CH_GT,     1'b1, 1'b1, '{CH_GT,   1'b1, 1'b0, 1'b1}},
		'{CH_LPAREN, 1'b1, 1'b1, '{CH_NUL,  1'b0, 1'b0, 1'b1}}
	};

	logic      clk;
	logic      arst_n;
	logic      char_valid;
	logic      char_stall;
	msk_in_t   char_data;
	logic      res_valid;
	logic      res_stall = 1'b0;
	msk_out_t  res_data;
	char_row_t cur_row;

	int send_pct = 0;
	int stall_pct = 0;
	int bad_count = 0;
	int planned;

	char_row_t plan[$];
	msk_out_t  skinned_q[$];
	msk_out_t  step_res[$];
	logic      step_end;

	msk_mode_t sk_mode = M_NORMAL;
	int        sk_depth = 0;
	logic      sk_owed = 1'b0;
	logic      sk_angle = 1'b0;

	mail_address_skinner i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("mail_address_skinner verification failed");
		$finish;
	end

	task automatic report_bad(input string msg);
		$display("%0t ERROR %s", $time, msg);
		bad_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_bad($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// ---- skinning model ----

	function automatic void emit(input logic [7:0] ch, input logic has, input logic rst);
		if (step_res.size() < MAX_RES)
			step_res.push_back('{out_char: ch, has_char: has, restart: rst, out_end: 1'b0});
	endfunction

	function automatic void keep_char(input logic [7:0] ch);
		if (sk_owed) begin
			sk_owed = 1'b0;
			emit(CH_SPACE, 1'b1, 1'b0);
		end
		emit(ch, 1'b1, 1'b0);
	endfunction

	function automatic void take_plain(input logic [7:0] ch);
		sk_mode = M_NORMAL;
		if (ch == CH_LPAREN) begin
			sk_depth = 1;
			sk_mode = M_COMMENT;
			sk_owed = 1'b0;
		end else if (ch == CH_SPACE) begin
			sk_mode = M_SPACE;
		end else if (ch == CH_LT) begin
			emit(CH_NUL, 1'b0, 1'b1);
			sk_angle = 1'b1;
			sk_owed = 1'b0;
		end else if (ch == CH_GT && sk_angle) begin
			sk_mode = M_DONE;
			step_end = 1'b1;
		end else begin
			keep_char(ch);
		end
	endfunction

	function automatic void skin_step(input msk_in_t it);
		logic [7:0] c;
		logic       was_done;
		msk_out_t   tail;
		c = it.in_char;
		was_done = (sk_mode == M_DONE);
		step_res.delete();
		step_end = 1'b0;
		case (sk_mode)
		M_DONE: ;
		M_COMMENT: begin
			if (c == CH_LPAREN) begin
				if (sk_depth < MAX_DEPTH)
					sk_depth++;
			end else if (c == CH_RPAREN) begin
				if (sk_depth > 0)
					sk_depth--;
				if (sk_depth == 0)
					sk_mode = M_SKIP;
			end
		end
		M_SKIP: sk_mode = M_NORMAL;
		M_SPACE: begin
			if (c == CH_A) begin
				sk_mode = M_SP_A;
			end else if (c == CH_AT) begin
				sk_mode = M_SP_ATSIGN;
			end else begin
				sk_owed = 1'b1;
				take_plain(c);
			end
		end
		M_SP_A: begin
			if (c == CH_T) begin
				sk_mode = M_SP_AT;
			end else begin
				sk_owed = 1'b1;
				keep_char(CH_A);
				take_plain(c);
			end
		end
		M_SP_AT: begin
			if (c == CH_SPACE) begin
				emit(CH_AT, 1'b1, 1'b0);
				sk_mode = M_NORMAL;
			end else begin
				sk_owed = 1'b1;
				keep_char(CH_A);
				keep_char(CH_T);
				take_plain(c);
			end
		end
		M_SP_ATSIGN: begin
			if (c == CH_SPACE) begin
				emit(CH_AT, 1'b1, 1'b0);
				sk_mode = M_NORMAL;
			end else begin
				sk_owed = 1'b1;
				keep_char(CH_AT);
				take_plain(c);
			end
		end
		default: take_plain(c);
		endcase

		// flush held lookahead at the end of the address
		if (it.in_last && !was_done && !step_end) begin
			case (sk_mode)
			M_SP_A: begin
				sk_owed = 1'b1;
				keep_char(CH_A);
			end
			M_SP_AT: begin
				sk_owed = 1'b1;
				keep_char(CH_A);
				keep_char(CH_T);
			end
			M_SP_ATSIGN: begin
				sk_owed = 1'b1;
				keep_char(CH_AT);
			end
			default: ;
			endcase
			step_end = 1'b1;
		end

		if (step_end) begin
			if (step_res.size() == 0)
				emit(CH_NUL, 1'b0, 1'b0);
			tail = step_res.pop_back();
			tail.out_end = 1'b1;
			step_res.push_back(tail);
		end

		if (it.in_last) begin
			sk_mode = M_NORMAL;
			sk_depth = 0;
			sk_owed = 1'b0;
			sk_angle = 1'b0;
		end
	endfunction

	// ---- monitors ----

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			skin_step(char_data);
			if (cur_row.known)
				skinned_q.push_back(cur_row.want);
			else
				foreach (step_res[i])
					skinned_q.push_back(step_res[i]);
		end
	end

	always @(posedge clk) begin
		msk_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (skinned_q.size() == 0) begin
				report_bad($sformatf("result transfer %h with nothing expected", res_data));
			end else begin
				want = skinned_q.pop_front();
				check_field("out_char", res_data.out_char, want.out_char);
				check_field("has_char", res_data.has_char, want.has_char);
				check_field("restart", res_data.restart, want.restart);
				check_field("out_end", res_data.out_end, want.out_end);
			end
		end
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// ---- stimulus ----

	task automatic queue_char(input logic [7:0] ch);
		plan.push_back('{ch: ch, last: 1'b0, known: 1'b0, want: UNTYPED});
		planned++;
	endtask

	task automatic close_address();
		char_row_t r;
		r = plan.pop_back();
		r.last = 1'b1;
		plan.push_back(r);
	endtask

	task automatic plan_address();
		int n;
		int k;
		int depth;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9))
			0, 1, 2: repeat ($urandom_range(1, 4))
				queue_char(8'($urandom_range(CH_A, 8'h7a)));
			3: repeat ($urandom_range(1, 3))
				queue_char(CH_SPACE);
			4: begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 4;
				for (k = 0; k < n; k++)
					queue_char(AT_WORD[k]);
			end
			5: begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
				for (k = 0; k < n; k++)
					queue_char(ATSIGN_WORD[k]);
			end
			6: begin
				queue_char(CH_LPAREN);
				depth = 1;
				n = $urandom_range(0, 8);
				for (k = 0; k < n && depth > 0; k++) begin
					case ($urandom_range(0, 3))
					0: begin
						queue_char(CH_LPAREN);
						depth++;
					end
					1: begin
						queue_char(CH_RPAREN);
						depth--;
					end
					default: queue_char(8'($urandom_range(1, 255)));
					endcase
				end
				if ($urandom_range(0, 5) != 0)
					repeat (depth) queue_char(CH_RPAREN);
				queue_char(8'($urandom_range(1, 255)));
			end
			7: begin
				queue_char(CH_LT);
				repeat ($urandom_range(1, 4))
					queue_char(8'($urandom_range(CH_A, 8'h7a)));
				if ($urandom_range(0, 3) != 0)
					queue_char(CH_GT);
			end
			8: queue_char(CH_GT);
			default: queue_char(8'($urandom_range(1, 255)));
			endcase
		end
		close_address();
	endtask

	task automatic send_row(input char_row_t r);
		while ($urandom_range(99) < send_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data <= '{in_char: r.ch, in_last: r.last};
		cur_row <= r;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		char_valid <= 1'b0;
		char_data <= '0;
		cur_row <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_row(DIRECTED[i]);

		for (int ph = 0; ph < 4; ph++) begin
			send_pct = SEND_PCT[ph];
			stall_pct = STALL_PCT[ph];
			planned = 0;
			while (planned < 72)
				plan_address();
			while (plan.size() != 0)
				send_row(plan.pop_front());
			char_valid <= 1'b0;
			@(posedge clk);
			while (skinned_q.size() != 0)
				@(posedge clk);
		end

		repeat (20) @(posedge clk);
		if (bad_count == 0)
			$display("mail_address_skinner verification clean");
		else
			$display("mail_address_skinner verification failed");
		$finish;
	end

endmodule
